FILE: hw/rtl/mwm_pkg.sv
// Shared types and constants for the mecanum wheel mixer.
package mwm_pkg;

    localparam int CMD_W       = 16;
    localparam int SUM_W       = 18;
    localparam int MAG_W       = 17;
    localparam int DUTY_W      = 8;
    localparam int WHEEL_COUNT = 4;

    localparam logic [DUTY_W-1:0] DEAD_ZONE_RESET = 8'd25;
    localparam logic [DUTY_W-1:0] DUTY_MAX        = 8'd255;

    // Wheel lane order
    localparam int WHEEL_FL = 0;
    localparam int WHEEL_FR = 1;
    localparam int WHEEL_RL = 2;
    localparam int WHEEL_RR = 3;

    typedef struct packed {
        logic signed [CMD_W-1:0] forward_cmd;
        logic signed [CMD_W-1:0] lateral_cmd;
        logic signed [CMD_W-1:0] rotate_cmd;
    } cmd_t;

    typedef struct packed {
        logic [DUTY_W-1:0] front_left_duty;
        logic              front_left_forward;
        logic [DUTY_W-1:0] front_right_duty;
        logic              front_right_forward;
        logic [DUTY_W-1:0] rear_left_duty;
        logic              rear_left_forward;
        logic [DUTY_W-1:0] rear_right_duty;
        logic              rear_right_forward;
    } result_t;

endpackage

FILE: hw/rtl/mwm_scale.sv
// Magnitude, peak search, divisor select and numerator multiply stage.
module mwm_scale
    import mwm_pkg::*;
#(
    parameter int DUTY_FULL_SCALE   = 255,
    parameter int COMMAND_FRAC_BITS = 14,
    parameter int NUM_W             = 25,
    parameter int DIV_W             = 17
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    valid_in,
    input  logic signed [SUM_W-1:0] wheel [WHEEL_COUNT],
    output logic                    valid_out,
    output logic [NUM_W-1:0]        num [WHEEL_COUNT],
    output logic [DIV_W-1:0]        div,
    output logic                    dir [WHEEL_COUNT]
);

    localparam logic [DIV_W-1:0] ONE      = DIV_W'(1) << COMMAND_FRAC_BITS;
    localparam logic [NUM_W-1:0] FS_CONST = NUM_W'(DUTY_FULL_SCALE);

    logic [MAG_W-1:0] mag [WHEEL_COUNT];
    logic [MAG_W-1:0] peak_a;
    logic [MAG_W-1:0] peak_b;
    logic [MAG_W-1:0] peak;

    logic             valid_reg;
    logic [NUM_W-1:0] num_reg [WHEEL_COUNT];
    logic [NUM_W-1:0] num_next [WHEEL_COUNT];
    logic [DIV_W-1:0] div_reg;
    logic [DIV_W-1:0] div_next;
    logic             dir_reg [WHEEL_COUNT];
    logic             dir_next [WHEEL_COUNT];

    always_comb
    begin
        for (int i = 0; i < WHEEL_COUNT; i++)
        begin
            mag[i]      = wheel[i][SUM_W-1] ? MAG_W'(-wheel[i]) : MAG_W'(wheel[i]);
            dir_next[i] = !wheel[i][SUM_W-1] && (wheel[i] != '0);
            num_next[i] = NUM_W'(mag[i]) * FS_CONST;
        end
        peak_a   = (mag[WHEEL_FL] > mag[WHEEL_FR]) ? mag[WHEEL_FL] : mag[WHEEL_FR];
        peak_b   = (mag[WHEEL_RL] > mag[WHEEL_RR]) ? mag[WHEEL_RL] : mag[WHEEL_RR];
        peak     = (peak_a > peak_b) ? peak_a : peak_b;
        // Scale down only when some wheel exceeds full speed
        div_next = (DIV_W'(peak) > ONE) ? DIV_W'(peak) : ONE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        div_reg <= div_next;
        for (int i = 0; i < WHEEL_COUNT; i++)
        begin
            num_reg[i] <= num_next[i];
            dir_reg[i] <= dir_next[i];
        end
    end

    assign valid_out = valid_reg;
    assign num       = num_reg;
    assign div       = div_reg;
    assign dir       = dir_reg;

endmodule

FILE: hw/rtl/mwm_div_cell.sv
// One restoring-division cell: resolves one quotient bit for all four wheels.
module mwm_div_cell
    import mwm_pkg::*;
#(
    parameter int SHIFT = 0,
    parameter int NUM_W = 25,
    parameter int DIV_W = 17,
    parameter int Q_W   = 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             valid_in,
    input  logic [NUM_W-1:0] rem_in [WHEEL_COUNT],
    input  logic [Q_W-1:0]   quo_in [WHEEL_COUNT],
    input  logic [DIV_W-1:0] div_in,
    input  logic             dir_in [WHEEL_COUNT],
    output logic             valid_out,
    output logic [NUM_W-1:0] rem_out [WHEEL_COUNT],
    output logic [Q_W-1:0]   quo_out [WHEEL_COUNT],
    output logic [DIV_W-1:0] div_out,
    output logic             dir_out [WHEEL_COUNT]
);

    localparam int CMP_W = (NUM_W > DIV_W + SHIFT) ? NUM_W : DIV_W + SHIFT;

    logic [CMP_W-1:0] step;
    logic [CMP_W-1:0] remx [WHEEL_COUNT];
    logic             take [WHEEL_COUNT];

    logic             valid_reg;
    logic [NUM_W-1:0] rem_reg [WHEEL_COUNT];
    logic [NUM_W-1:0] rem_next [WHEEL_COUNT];
    logic [Q_W-1:0]   quo_reg [WHEEL_COUNT];
    logic [Q_W-1:0]   quo_next [WHEEL_COUNT];
    logic [DIV_W-1:0] div_reg;
    logic             dir_reg [WHEEL_COUNT];

    always_comb
    begin
        step = CMP_W'(div_in) << SHIFT;
        for (int i = 0; i < WHEEL_COUNT; i++)
        begin
            remx[i]     = CMP_W'(rem_in[i]);
            take[i]     = (remx[i] >= step);
            rem_next[i] = take[i] ? NUM_W'(remx[i] - step) : rem_in[i];
            // Append the new quotient bit at the bottom
            quo_next[i] = Q_W'({quo_in[i], take[i]});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        div_reg <= div_in;
        for (int i = 0; i < WHEEL_COUNT; i++)
        begin
            rem_reg[i] <= rem_next[i];
            quo_reg[i] <= quo_next[i];
            dir_reg[i] <= dir_in[i];
        end
    end

    assign valid_out = valid_reg;
    assign rem_out   = rem_reg;
    assign quo_out   = quo_reg;
    assign div_out   = div_reg;
    assign dir_out   = dir_reg;

endmodule

FILE: hw/rtl/mwm_duty.sv
// Output stage: saturate quotient to 8 bits, apply dead zone, register result.
module mwm_duty
    import mwm_pkg::*;
#(
    parameter int Q_W = 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              valid_in,
    input  logic [Q_W-1:0]    quo [WHEEL_COUNT],
    input  logic              dir [WHEEL_COUNT],
    input  logic [DUTY_W-1:0] dead_zone,
    output logic              done,
    output result_t           result
);

    localparam int SAT_W = (Q_W > DUTY_W) ? Q_W : DUTY_W;

    logic [SAT_W-1:0]  qx [WHEEL_COUNT];
    logic [DUTY_W-1:0] sat [WHEEL_COUNT];
    logic [DUTY_W-1:0] duty [WHEEL_COUNT];

    logic    done_reg;
    result_t result_reg;
    result_t result_next;

    always_comb
    begin
        for (int i = 0; i < WHEEL_COUNT; i++)
        begin
            qx[i]   = SAT_W'(quo[i]);
            sat[i]  = (qx[i] > SAT_W'(DUTY_MAX)) ? DUTY_MAX : qx[i][DUTY_W-1:0];
            duty[i] = (sat[i] < dead_zone) ? '0 : sat[i];
        end
        result_next.front_left_duty     = duty[WHEEL_FL];
        result_next.front_left_forward  = dir[WHEEL_FL];
        result_next.front_right_duty    = duty[WHEEL_FR];
        result_next.front_right_forward = dir[WHEEL_FR];
        result_next.rear_left_duty      = duty[WHEEL_RL];
        result_next.rear_left_forward   = dir[WHEEL_RL];
        result_next.rear_right_duty     = duty[WHEEL_RR];
        result_next.rear_right_forward  = dir[WHEEL_RR];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

FILE: hw/rtl/mecanum_wheel_mixer_core.sv
// Top level of the mecanum wheel mixer: mix, scale, divider chain, duty output.
//
// Usage: raise start with a motion command on cmd (forward, lateral, rotate,
// signed fixed point). The command is taken at the rising edge where start is
// high and busy is low; busy stays low, so a new item may be presented every
// cycle. Each item yields one result: done pulses for one cycle with the four
// wheel duties and direction bits on result, once the item has passed through
// every stage of the pipeline described below.
// The pipeline is a mixing register, a scaling stage with one multiplier per
// wheel, a chain of division cells that each resolve one quotient bit for all
// four wheels, and a registered output stage; it sustains one item per cycle.
// The receiver cannot stall: a result is shown for one cycle and then is gone.
// dead_zone_we writes dead_zone_wdata into the dead zone register; write it
// only while no item is in flight.
// Reset clears every valid flag, so nothing is in flight afterwards, and sets
// the dead zone to 25.
module mecanum_wheel_mixer_core
    import mwm_pkg::*;
#(
    parameter int DUTY_FULL_SCALE   = 255,
    parameter int COMMAND_FRAC_BITS = 14
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  cmd_t              cmd,
    output logic              done,
    output result_t           result,
    input  logic              dead_zone_we,
    input  logic [DUTY_W-1:0] dead_zone_wdata
);

    localparam int Q_W     = $clog2(DUTY_FULL_SCALE + 1);
    localparam int DIV_W   = (MAG_W > COMMAND_FRAC_BITS + 1) ? MAG_W : COMMAND_FRAC_BITS + 1;
    localparam int NUM_W   = MAG_W + Q_W;
    localparam int LATENCY = Q_W + 3;

    logic                    accept;
    logic signed [SUM_W-1:0] x_s;
    logic signed [SUM_W-1:0] y_s;
    logic signed [SUM_W-1:0] z_s;

    logic                    valid_reg;
    logic signed [SUM_W-1:0] wheel_reg [WHEEL_COUNT];
    logic signed [SUM_W-1:0] wheel_next [WHEEL_COUNT];
    logic [DUTY_W-1:0]       dead_zone_reg;

    logic             stage_valid [Q_W+1];
    logic [NUM_W-1:0] stage_rem [Q_W+1][WHEEL_COUNT];
    logic [Q_W-1:0]   stage_quo [Q_W+1][WHEEL_COUNT];
    logic [DIV_W-1:0] stage_div [Q_W+1];
    logic             stage_dir [Q_W+1][WHEEL_COUNT];

    // Fully pipelined: never hold off an item
    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_comb
    begin
        x_s = SUM_W'(cmd.forward_cmd);
        y_s = SUM_W'(cmd.lateral_cmd);
        z_s = SUM_W'(cmd.rotate_cmd);
        wheel_next[WHEEL_FL] = x_s + y_s + z_s;
        wheel_next[WHEEL_FR] = x_s - y_s - z_s;
        wheel_next[WHEEL_RL] = x_s - y_s + z_s;
        wheel_next[WHEEL_RR] = x_s + y_s - z_s;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= 1'b0;
            dead_zone_reg <= DEAD_ZONE_RESET;
        end
        else
        begin
            valid_reg <= accept;
            if (dead_zone_we)
            begin
                dead_zone_reg <= dead_zone_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < WHEEL_COUNT; i++)
        begin
            wheel_reg[i] <= wheel_next[i];
        end
    end

    mwm_scale #(
        .DUTY_FULL_SCALE   (DUTY_FULL_SCALE),
        .COMMAND_FRAC_BITS (COMMAND_FRAC_BITS),
        .NUM_W             (NUM_W),
        .DIV_W             (DIV_W)
    ) u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (valid_reg),
        .wheel     (wheel_reg),
        .valid_out (stage_valid[0]),
        .num       (stage_rem[0]),
        .div       (stage_div[0]),
        .dir       (stage_dir[0])
    );

    for (genvar i = 0; i < WHEEL_COUNT; i++)
    begin : g_quo_init
        assign stage_quo[0][i] = '0;
    end

    // Most significant quotient bit first
    for (genvar j = 0; j < Q_W; j++)
    begin : g_cell
        mwm_div_cell #(
            .SHIFT (Q_W - 1 - j),
            .NUM_W (NUM_W),
            .DIV_W (DIV_W),
            .Q_W   (Q_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .valid_in  (stage_valid[j]),
            .rem_in    (stage_rem[j]),
            .quo_in    (stage_quo[j]),
            .div_in    (stage_div[j]),
            .dir_in    (stage_dir[j]),
            .valid_out (stage_valid[j+1]),
            .rem_out   (stage_rem[j+1]),
            .quo_out   (stage_quo[j+1]),
            .div_out   (stage_div[j+1]),
            .dir_out   (stage_dir[j+1])
        );
    end

    mwm_duty #(
        .Q_W (Q_W)
    ) u_duty (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (stage_valid[Q_W]),
        .quo       (stage_quo[Q_W]),
        .dir       (stage_dir[Q_W]),
        .dead_zone (dead_zone_reg),
        .done      (done),
        .result    (result)
    );

    a_done_has_item: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, LATENCY))
        else $error("result strobe without an item taken LATENCY cycles before");

    a_item_gives_done: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##LATENCY done)
        else $error("item taken but no result after LATENCY cycles");

    a_dead_zone_fl: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.front_left_duty != '0)) |->
            (result.front_left_duty >= dead_zone_reg))
        else $error("front left duty inside dead zone");

    a_dead_zone_rr: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.rear_right_duty != '0)) |->
            (result.rear_right_duty >= dead_zone_reg))
        else $error("rear right duty inside dead zone");

endmodule

FILE: bench/tb_mecanum_wheel_mixer_core.sv
// Self-checking testbench for the mecanum wheel mixer core with a built-in wheel predictor.
module tb_mecanum_wheel_mixer_core;
    import mwm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DUTY_SCALE   = 255;
    localparam int FRAC_BITS    = 14;
    localparam int PROD_W       = MAG_W + 8;
    localparam int LATENCY      = $clog2(DUTY_SCALE + 1) + 3;
    localparam int SETTLE       = LATENCY + 8;
    localparam int IDLE_LIMIT   = 2000;
    localparam int RANDOM_ITEMS = 1350;
    localparam int PHASES       = 6;

    typedef enum logic [1:0] {ACT_CMD, ACT_DEAD_ZONE, ACT_DRAIN} action_t;

    typedef struct {
        action_t           kind;
        cmd_t              command;
        logic [DUTY_W-1:0] dz_value;
    } stim_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    cmd_t              cmd = '0;
    logic              done;
    result_t           result;
    logic              dead_zone_we = 1'b0;
    logic [DUTY_W-1:0] dead_zone_wdata = '0;

    stim_t             pending_items[$];
    result_t           wheel_queue[$];
    logic [DUTY_W-1:0] dead_zone_shadow = DEAD_ZONE_RESET;
    int                commands_sent = 0;
    int                results_seen = 0;
    int                dz_writes = 0;
    int                mismatches = 0;
    int                burst_left = 1;
    int                gap_left = 0;
    int                idle_cycles = 0;

    mecanum_wheel_mixer_core dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .cmd             (cmd),
        .done            (done),
        .result          (result),
        .dead_zone_we    (dead_zone_we),
        .dead_zone_wdata (dead_zone_wdata)
    );

    always #4 clk = ~clk;

    // Mix, scale by the peak wheel when it exceeds full speed, and convert each wheel to duty and direction.
    function automatic result_t predict_wheels(cmd_t c, logic [DUTY_W-1:0] dz);
        logic signed [SUM_W-1:0] fx;
        logic signed [SUM_W-1:0] fy;
        logic signed [SUM_W-1:0] fz;
        logic signed [SUM_W-1:0] speed [WHEEL_COUNT];
        logic [MAG_W-1:0]        speed_mag [WHEEL_COUNT];
        logic [DUTY_W-1:0]       duty [WHEEL_COUNT];
        logic                    fwd [WHEEL_COUNT];
        logic [MAG_W-1:0]        peak;
        logic [MAG_W-1:0]        divisor;
        logic [PROD_W-1:0]       quotient;
        result_t                 r;
        fx = SUM_W'(c.forward_cmd);
        fy = SUM_W'(c.lateral_cmd);
        fz = SUM_W'(c.rotate_cmd);
        speed[WHEEL_FL] = fx + fy + fz;
        speed[WHEEL_FR] = fx - fy - fz;
        speed[WHEEL_RL] = fx - fy + fz;
        speed[WHEEL_RR] = fx + fy - fz;
        peak = '0;
        for (int i = 0; i < WHEEL_COUNT; i++)
        begin
            speed_mag[i] = (speed[i] < 0) ? MAG_W'(-speed[i]) : MAG_W'(speed[i]);
            if (speed_mag[i] > peak)
                peak = speed_mag[i];
        end
        divisor = (peak > MAG_W'(1 << FRAC_BITS)) ? peak : MAG_W'(1 << FRAC_BITS);
        for (int i = 0; i < WHEEL_COUNT; i++)
        begin
            quotient = (PROD_W'(speed_mag[i]) * PROD_W'(DUTY_SCALE)) / PROD_W'(divisor);
            if (quotient > PROD_W'(DUTY_MAX))
                quotient = PROD_W'(DUTY_MAX);
            duty[i] = (quotient < PROD_W'(dz)) ? '0 : quotient[DUTY_W-1:0];
            fwd[i]  = (speed[i] > 0);
        end
        r.front_left_duty     = duty[WHEEL_FL];
        r.front_left_forward  = fwd[WHEEL_FL];
        r.front_right_duty    = duty[WHEEL_FR];
        r.front_right_forward = fwd[WHEEL_FR];
        r.rear_left_duty      = duty[WHEEL_RL];
        r.rear_left_forward   = fwd[WHEEL_RL];
        r.rear_right_duty     = duty[WHEEL_RR];
        r.rear_right_forward  = fwd[WHEEL_RR];
        return r;
    endfunction

    function automatic logic signed [CMD_W-1:0] random_axis(bit gentle);
        int v;
        if (gentle)
        begin
            v = int'($urandom_range(0, 10922)) - 5461;
            return CMD_W'(v);
        end
        case ($urandom_range(0, 11))
            0: v = -32768;
            1: v = 32767;
            2: v = 0;
            3: v = 16384;
            4: v = -16384;
            5, 6: v = int'($urandom_range(0, 4000)) - 2000;
            default: v = int'($urandom);
        endcase
        return CMD_W'(v);
    endfunction

    task automatic add_cmd(int x, int y, int z);
        stim_t s;
        s.kind     = ACT_CMD;
        s.command  = '{forward_cmd: CMD_W'(x), lateral_cmd: CMD_W'(y), rotate_cmd: CMD_W'(z)};
        s.dz_value = '0;
        pending_items.push_back(s);
    endtask

    task automatic add_action(action_t kind, logic [DUTY_W-1:0] dz);
        stim_t s;
        s.kind     = kind;
        s.command  = '0;
        s.dz_value = dz;
        pending_items.push_back(s);
    endtask

    task automatic check_field(input string field, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", field, want, got);
            mismatches++;
        end
    endtask

    // Driver: present queued items in bursts, hold config writes until the pipe is empty.
    always @(posedge clk)
    begin : driver
        logic              next_start;
        logic              next_we;
        cmd_t              next_cmd;
        logic [DUTY_W-1:0] next_wdata;
        next_start = 1'b0;
        next_we    = 1'b0;
        next_cmd   = cmd;
        next_wdata = dead_zone_wdata;
        if (rst_n)
        begin
            if (dead_zone_we)
                dead_zone_shadow = dead_zone_wdata;
            if (start && !busy)
            begin
                wheel_queue.push_back(predict_wheels(cmd, dead_zone_shadow));
                void'(pending_items.pop_front());
                commands_sent++;
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 48);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
                end
            end
            if (gap_left > 0)
                gap_left--;
            else if (pending_items.size() > 0)
            begin
                case (pending_items[0].kind)
                    ACT_CMD:
                    begin
                        next_start = 1'b1;
                        next_cmd   = pending_items[0].command;
                    end
                    ACT_DEAD_ZONE:
                    begin
                        if (wheel_queue.size() == 0 && !start && !dead_zone_we)
                        begin
                            next_we    = 1'b1;
                            next_wdata = pending_items[0].dz_value;
                            dz_writes++;
                            void'(pending_items.pop_front());
                        end
                    end
                    ACT_DRAIN:
                    begin
                        if (wheel_queue.size() == 0 && !start)
                            void'(pending_items.pop_front());
                    end
                    default: ;
                endcase
            end
        end
        start           <= next_start;
        cmd             <= next_cmd;
        dead_zone_we    <= next_we;
        dead_zone_wdata <= next_wdata;
    end

    // Monitor: compare every result strobe against the oldest prediction.
    always @(posedge clk)
    begin : monitor
        result_t want;
        if (rst_n && done)
        begin
            results_seen++;
            if (wheel_queue.size() == 0)
            begin
                $error("result with no command outstanding");
                mismatches++;
            end
            else
            begin
                want = wheel_queue.pop_front();
                check_field("front_left_duty", want.front_left_duty, result.front_left_duty);
                check_field("front_left_forward", want.front_left_forward,
                            result.front_left_forward);
                check_field("front_right_duty", want.front_right_duty, result.front_right_duty);
                check_field("front_right_forward", want.front_right_forward,
                            result.front_right_forward);
                check_field("rear_left_duty", want.rear_left_duty, result.rear_left_duty);
                check_field("rear_left_forward", want.rear_left_forward,
                            result.rear_left_forward);
                check_field("rear_right_duty", want.rear_right_duty, result.rear_right_duty);
                check_field("rear_right_forward", want.rear_right_forward,
                            result.rear_right_forward);
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long.
    always @(posedge clk)
    begin : watchdog
        if (rst_n)
        begin
            if ((start && !busy) || done || dead_zone_we)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Timeout: no activity for %0d cycles", IDLE_LIMIT);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        logic [DUTY_W-1:0] phase_dz;
        bit                gentle;
        int                per_phase;

        // Directed: zero, extremes, exact full scale, just above it, dead zone edges.
        add_cmd(0, 0, 0);
        add_cmd(32767, 0, 0);
        add_cmd(-32768, 0, 0);
        add_cmd(0, 32767, 0);
        add_cmd(0, -32768, 0);
        add_cmd(0, 0, 32767);
        add_cmd(0, 0, -32768);
        add_cmd(32767, 32767, 32767);
        add_cmd(-32768, -32768, -32768);
        add_cmd(-32768, 32767, -32768);
        add_cmd(16384, 0, 0);
        add_cmd(16385, 0, 0);
        add_cmd(-16384, 0, 0);
        add_cmd(1000, 0, 0);
        add_cmd(1, 0, 0);
        add_cmd(-1, 0, 0);
        add_cmd(5000, 5000, 0);
        add_cmd(8192, 4096, -4096);
        add_cmd(1606, 0, 0);
        add_cmd(1671, 0, 0);
        add_action(ACT_DEAD_ZONE, 8'd0);
        add_cmd(1000, 0, 0);
        add_cmd(1, 0, 0);
        add_action(ACT_DEAD_ZONE, 8'd255);
        add_cmd(16384, 0, 0);
        add_cmd(16320, 0, 0);
        add_cmd(32767, -32768, 1);

        // Random phases, each under its own dead zone, with a few forced drains.
        per_phase = RANDOM_ITEMS / PHASES;
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0: phase_dz = 8'd0;
                1: phase_dz = DUTY_MAX;
                2: phase_dz = 8'd1;
                3: phase_dz = DEAD_ZONE_RESET;
                default: phase_dz = DUTY_W'($urandom);
            endcase
            add_action(ACT_DEAD_ZONE, phase_dz);
            for (int i = 0; i < per_phase; i++)
            begin
                gentle = ($urandom_range(0, 99) < 35);
                add_cmd(random_axis(gentle), random_axis(gentle), random_axis(gentle));
                if ($urandom_range(0, 99) == 0)
                    add_action(ACT_DRAIN, '0);
            end
            add_action(ACT_DRAIN, '0);
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_items.size() != 0 || wheel_queue.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        $display("Covered %0d motion commands and %0d wheel results under %0d dead zone writes",
                 commands_sent, results_seen, dz_writes);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
